// File: src/psm_pkg.sv
// Shared types and constants for the planar shape matching block.
// Holds the request and response records of the serial divider and square root units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

    // width that the block sums are brought down to before the solve
    localparam int NORM_W = 24;

    // saturation limits of M entries and of the output entries
    localparam logic [30:0] M_LIMIT   = 31'h3FFF_FFFF;
    localparam logic [30:0] OUT_LIMIT = 31'h7FFF_FFFF;

    // rounded, saturated division request
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic        [30:0] lim;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

    // integer square root request
    typedef struct packed {
        logic        start;
        logic [63:0] val;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;

endpackage

`default_nettype wire

// File: src/psm_div.sv
// Serial divider: round(num/den) half away from zero, saturated to +-lim.
// One quotient bit per cycle for all 64 bits, after the operands are loaded. Uses psm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psm_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire psm_pkg::t_div_req i_req,
    output psm_pkg::t_div_rsp     o_rsp
);
    import psm_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_d;
    logic [63:0] r_n;
    logic [64:0] r_rem;
    logic [63:0] r_q;
    logic        r_neg;
    logic [30:0] r_lim;
    logic        r_done;
    logic signed [31:0] r_quo;

    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [64:0] rem_s;
    logic        ge;
    logic [63:0] q_new;
    logic [30:0] q_sat;

    // operand magnitudes
    assign num_mag = i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
    assign den_mag = i_req.den[63] ? 64'(-i_req.den) : 64'(i_req.den);

    // one restoring step
    assign rem_s = {r_rem[63:0], r_n[63]};
    assign ge    = rem_s >= {1'b0, r_d};
    assign q_new = {r_q[62:0], ge};
    assign q_sat = (q_new > {33'b0, r_lim}) ? r_lim : q_new[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_d    <= den_mag;
            r_n    <= num_mag + (den_mag >> 1);
            r_rem  <= '0;
            r_q    <= '0;
            r_neg  <= i_req.num[63] ^ i_req.den[63];
            r_lim  <= i_req.lim;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= ge ? (rem_s - {1'b0, r_d}) : rem_s;
            r_q    <= q_new;
            r_n    <= {r_n[62:0], 1'b0};
            r_cnt  <= r_cnt + 6'd1;
            r_done <= (r_cnt == 6'd63);
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_quo  <= r_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// File: src/psm_sqrt.sv
// Serial integer square root, floor(sqrt(val)) of a 64 bit value.
// Two radicand bits per cycle, after the value is loaded. Uses psm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psm_sqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psm_pkg::t_sqrt_req i_req,
    output psm_pkg::t_sqrt_rsp     o_rsp
);
    import psm_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic        r_done;

    logic [35:0] rem_s;
    logic [35:0] trial;
    logic        ge;

    // bring down two bits and try the next root bit
    assign rem_s = {r_rem[33:0], r_v[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = rem_s >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_v    <= i_req.val;
            r_rem  <= '0;
            r_root <= '0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= ge ? (rem_s - trial) : rem_s;
            r_root <= {r_root[30:0], ge};
            r_v    <= {r_v[61:0], 2'b00};
            r_cnt  <= r_cnt + 5'd1;
            r_done <= (r_cnt == 5'd31);
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

`default_nettype wire

// File: src/planar_shape_match_polar.sv
// Top level of the planar shape matching block: sequencer, shared multiplier, sums.
// Depends on psm_pkg, psm_div and psm_sqrt.
`timescale 1ns / 1ps
`default_nettype none

// Accumulates Apq = sum t*r^T and Aqq = sum r*r^T over point pairs and, on the
// pair marked last, solves M = Apq*Aqq^-1 and splits it into a symmetric S and
// an orthogonal R (Q16.16, saturated); a singular Aqq or M gives zeros and the
// singular flag. All products run through one 32x32 multiplier with a
// registered product, so a pair that is not last runs its 7 products in turn
// after the idle state takes the beat. A last pair adds the solve: block
// normalization, one bit per cycle (up to 2*COORD_WIDTH-14 bits), 18 products,
// 10 divisions on the 64-step serial divider, one square root and the load of
// the result. The result sits in an output register, so the next set
// accumulates while it waits.
module planar_shape_match_polar #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_trans_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_trans_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ref_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ref_y,
    input  wire logic                          i_last,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [31:0]                 o_s_xx,
    output logic signed [31:0]                 o_s_xy,
    output logic signed [31:0]                 o_s_yy,
    output logic signed [31:0]                 o_r_xx,
    output logic signed [31:0]                 o_r_xy,
    output logic signed [31:0]                 o_r_yx,
    output logic signed [31:0]                 o_r_yy,
    output logic                               o_singular
);
    import psm_pkg::*;

    localparam int SW = 2 * COORD_WIDTH + 10;

    typedef enum logic [4:0] {
        S_IDLE, S_ACC, S_NORM, S_DEN_A, S_DEN_B, S_NUM_A, S_NUM_B, S_DIV_M,
        S_DET_A, S_DET_B, S_P00_A, S_P00_B, S_P01_A, S_P01_B, S_P11_A, S_P11_B,
        S_SQRT, S_DIV_O, S_FIN
    } t_state;

    t_state r_state;
    logic   r_ph;
    logic [2:0] r_idx;

    logic signed [COORD_WIDTH-1:0] r_tx, r_ty, r_rx, r_ry;
    logic r_last;

    logic signed [SW-1:0] r_sum [7];
    logic signed [63:0] r_prod, r_acc, r_den, r_adet, r_p00, r_p01, r_p11;
    logic signed [31:0] r_m [4];
    logic signed [31:0] r_res [6];
    logic [31:0] r_qs;
    logic r_rot, r_sing;

    logic r_oval;
    logic signed [31:0] r_o [7];
    logic r_osing;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p, acc_sub, acc_add;
    logic signed [63:0] x1, x2, x3;
    logic [6:0] fit;
    logic all_fit;
    logic [2:0] idx_pair;
    logic out_free;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    // normalized sum as a multiplier operand
    function automatic logic signed [31:0] nrm(input logic signed [SW-1:0] v);
        return {{(32 - NORM_W){v[NORM_W-1]}}, v[NORM_W-1:0]};
    endfunction

    // block normalization check: every sum fits the normalized width
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            fit[i] = (&r_sum[i][SW-1:NORM_W-1]) | ~(|r_sum[i][SW-1:NORM_W-1]);
        end
    end
    assign all_fit = &fit;

    assign idx_pair = {r_idx[2:1], ~r_idx[0]};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_ACC: begin
                unique case (r_idx)
                    3'd0: begin mul_a = 32'(r_tx); mul_b = 32'(r_rx); end
                    3'd1: begin mul_a = 32'(r_tx); mul_b = 32'(r_ry); end
                    3'd2: begin mul_a = 32'(r_ty); mul_b = 32'(r_rx); end
                    3'd3: begin mul_a = 32'(r_ty); mul_b = 32'(r_ry); end
                    3'd4: begin mul_a = 32'(r_rx); mul_b = 32'(r_rx); end
                    3'd5: begin mul_a = 32'(r_rx); mul_b = 32'(r_ry); end
                    3'd6: begin mul_a = 32'(r_ry); mul_b = 32'(r_ry); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_DEN_A: begin mul_a = nrm(r_sum[4]); mul_b = nrm(r_sum[6]); end
            S_DEN_B: begin mul_a = nrm(r_sum[5]); mul_b = nrm(r_sum[5]); end
            S_NUM_A: begin
                mul_a = nrm(r_sum[r_idx]);
                mul_b = r_idx[0] ? nrm(r_sum[4]) : nrm(r_sum[6]);
            end
            S_NUM_B: begin mul_a = nrm(r_sum[idx_pair]); mul_b = nrm(r_sum[5]); end
            S_DET_A: begin mul_a = r_m[0]; mul_b = r_m[3]; end
            S_DET_B: begin mul_a = r_m[1]; mul_b = r_m[2]; end
            S_P00_A: begin mul_a = r_m[0]; mul_b = r_m[0]; end
            S_P00_B: begin mul_a = r_m[1]; mul_b = r_m[1]; end
            S_P01_A: begin mul_a = r_m[0]; mul_b = r_m[2]; end
            S_P01_B: begin mul_a = r_m[1]; mul_b = r_m[3]; end
            S_P11_A: begin mul_a = r_m[2]; mul_b = r_m[2]; end
            S_P11_B: begin mul_a = r_m[3]; mul_b = r_m[3]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sub = r_acc - r_prod;
    assign acc_add = r_acc + r_prod;

    // numerators of R, chosen by rotation or reflection
    assign x1 = r_rot ? (64'(r_m[0]) + 64'(r_m[3])) : (64'(r_m[0]) - 64'(r_m[3]));
    assign x2 = r_rot ? (64'(r_m[1]) - 64'(r_m[2])) : (64'(r_m[1]) + 64'(r_m[2]));
    assign x3 = r_rot ? (64'(r_m[2]) - 64'(r_m[1])) : (64'(r_m[3]) - 64'(r_m[0]));

    // divider and square root requests
    always_comb begin
        div_req.start = ((r_state == S_DIV_M) || (r_state == S_DIV_O)) && !r_ph;
        div_req.num   = '0;
        div_req.den   = r_den;
        div_req.lim   = M_LIMIT;
        if (r_state == S_DIV_M) begin
            div_req.num = r_acc <<< 16;
        end else begin
            div_req.den = $signed({32'b0, r_qs});
            div_req.lim = OUT_LIMIT;
            unique case (r_idx)
                3'd0: div_req.num = r_p00 + r_adet;
                3'd1: div_req.num = r_p01;
                3'd2: div_req.num = r_p11 + r_adet;
                3'd3: div_req.num = x1 <<< 16;
                3'd4: div_req.num = x2 <<< 16;
                3'd5: div_req.num = x3 <<< 16;
                default: div_req.num = '0;
            endcase
        end
    end

    assign sqrt_req.start = (r_state == S_SQRT) && !r_ph;
    assign sqrt_req.val   = 64'(r_p00) + 64'(r_p11) + {r_adet[62:0], 1'b0};

    psm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    psm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign out_free = !r_oval || !i_stall;

    // sequencer, sums and output register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_idx   <= '0;
            r_oval  <= 1'b0;
            for (int i = 0; i < 7; i++) r_sum[i] <= '0;
        end else begin
            // output beat loads from the final step or leaves when taken
            if (r_state == S_FIN && out_free) r_oval <= 1'b1;
            else if (r_oval && !i_stall) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tx    <= i_trans_x;
                        r_ty    <= i_trans_y;
                        r_rx    <= i_ref_x;
                        r_ry    <= i_ref_y;
                        r_last  <= i_last;
                        r_idx   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_sum[r_idx] <= r_sum[r_idx] + r_prod[SW-1:0];
                        if (r_idx == 3'd6) begin
                            r_idx   <= '0;
                            r_state <= r_last ? S_NORM : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                S_NORM: begin
                    if (all_fit) begin
                        r_state <= S_DEN_A;
                    end else begin
                        for (int i = 0; i < 7; i++) r_sum[i] <= r_sum[i] >>> 1;
                    end
                end
                S_DEN_A, S_NUM_A, S_DET_A, S_P00_A, S_P01_A, S_P11_A: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc   <= r_prod;
                        r_state <= t_state'(r_state + 5'd1);
                    end
                end
                S_DEN_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_den <= acc_sub;
                        r_idx <= '0;
                        if (acc_sub == 64'sd0) begin
                            r_sing  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_sing  <= 1'b0;
                            r_state <= S_NUM_A;
                        end
                    end
                end
                S_NUM_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc   <= acc_sub;
                        r_state <= S_DIV_M;
                    end
                end
                S_DIV_M: begin
                    if (r_ph && div_rsp.done) begin
                        r_m[r_idx[1:0]] <= div_rsp.quo;
                        r_ph <= 1'b0;
                        if (r_idx == 3'd3) begin
                            r_idx   <= '0;
                            r_state <= S_DET_A;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_NUM_A;
                        end
                    end else begin
                        r_ph <= 1'b1;
                    end
                end
                S_DET_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_adet <= acc_sub[63] ? -acc_sub : acc_sub;
                        r_rot  <= !acc_sub[63];
                        if (acc_sub == 64'sd0) begin
                            r_sing  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_P00_A;
                        end
                    end
                end
                S_P00_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_p00   <= acc_add;
                        r_state <= S_P01_A;
                    end
                end
                S_P01_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_p01   <= acc_add;
                        r_state <= S_P11_A;
                    end
                end
                S_P11_B: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_p11   <= acc_add;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_ph && sqrt_rsp.done) begin
                        r_qs    <= sqrt_rsp.root;
                        r_ph    <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_DIV_O;
                    end else begin
                        r_ph <= 1'b1;
                    end
                end
                S_DIV_O: begin
                    if (r_ph && div_rsp.done) begin
                        r_res[r_idx] <= div_rsp.quo;
                        r_ph <= 1'b0;
                        if (r_idx == 3'd5) begin
                            r_idx   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end else begin
                        r_ph <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_osing <= r_sing;
                        if (r_sing) begin
                            for (int i = 0; i < 7; i++) r_o[i] <= '0;
                        end else begin
                            r_o[0] <= r_res[0];
                            r_o[1] <= r_res[1];
                            r_o[2] <= r_res[2];
                            r_o[3] <= r_res[3];
                            r_o[4] <= r_res[4];
                            r_o[5] <= r_rot ? r_res[5] : r_res[4];
                            r_o[6] <= r_rot ? r_res[3] : r_res[5];
                        end
                        for (int i = 0; i < 7; i++) r_sum[i] <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid    = r_oval;
    assign o_s_xx     = r_o[0];
    assign o_s_xy     = r_o[1];
    assign o_s_yy     = r_o[2];
    assign o_r_xx     = r_o[3];
    assign o_r_xy     = r_o[4];
    assign o_r_yx     = r_o[5];
    assign o_r_yy     = r_o[6];
    assign o_singular = r_osing;

    // a singular beat carries all-zero matrices
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_s_xx == 0 && o_s_xy == 0 && o_s_yy == 0 &&
            o_r_xx == 0 && o_r_xy == 0 && o_r_yx == 0 && o_r_yy == 0))
        else $error("singular result with nonzero fields");

    // divider only answers inside a division step
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_M || r_state == S_DIV_O))
        else $error("divider result outside a division step");

    // sums 0, 3, 4, 6 are empty once a result is handed to the output register
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_FIN) |->
            (r_sum[0] == 0 && r_sum[3] == 0 && r_sum[4] == 0 && r_sum[6] == 0 && o_valid))
        else $error("sums not cleared after a result");

endmodule

`default_nettype wire

// File: tb/tb_planar_shape_match_polar.sv
// Self-checking testbench for planar_shape_match_polar: point pairs in, S and R out.
// Predicts the polar decomposition in SystemVerilog and checks each result beat.
// Depends on psm_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_planar_shape_match_polar;
    import psm_pkg::*;

    localparam int CW = 16;
    localparam int SUM_W = 2 * CW + 10;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic signed [31:0] s_xx, s_xy, s_yy, r_xx, r_xy, r_yx, r_yy;
        logic               singular;
    } t_shape;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [CW-1:0] i_trans_x = '0, i_trans_y = '0, i_ref_x = '0, i_ref_y = '0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_s_xx, o_s_xy, o_s_yy, o_r_xx, o_r_xy, o_r_yx, o_r_yy;
    logic o_singular;

    planar_shape_match_polar #(.COORD_WIDTH(CW)) dut (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: running sums of the current set
    logic [SUM_W-1:0] cross_acc [4];
    logic [SUM_W-1:0] ref_acc [3];
    t_shape expected_shapes [$];
    int errors = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    // rounded division, half away from zero, saturated
    function automatic longint div_rnd(longint num, int sh, longint den, longint lim);
        logic [63:0] n, d, q;
        logic neg;
        n = (num < 0 ? -num : num);
        n = n << sh;
        d = (den < 0 ? -den : den);
        q = (n + d / 2) / d;
        neg = (num < 0) != (den < 0);
        if (q > lim) q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_shape solve_shape();
        t_shape res;
        longint v [7];
        longint p00, p01, p10, p11, a, b, c, den, m0, m1, m2, m3, detm, adet;
        longint pp00, pp01, pp11, qs, lo, hi;
        int k;
        bit fits;
        res = '{default: '0};
        res.singular = 1'b1;
        for (int i = 0; i < 4; i++) v[i] = longint'($signed(cross_acc[i]));
        for (int i = 0; i < 3; i++) v[4+i] = longint'($signed(ref_acc[i]));
        lo = -(longint'(1) << (NORM_W - 1));
        hi = -lo - 1;
        k = 0;
        fits = 0;
        while (!fits && k < SUM_W) begin
            fits = 1;
            for (int i = 0; i < 7; i++)
                if (floor_shr(v[i], k) < lo || floor_shr(v[i], k) > hi) fits = 0;
            if (!fits) k++;
        end
        p00 = floor_shr(v[0], k); p01 = floor_shr(v[1], k);
        p10 = floor_shr(v[2], k); p11 = floor_shr(v[3], k);
        a = floor_shr(v[4], k); b = floor_shr(v[5], k); c = floor_shr(v[6], k);
        den = a * c - b * b;
        if (den == 0) return res;
        m0 = div_rnd(p00 * c - p01 * b, 16, den, M_LIMIT);
        m1 = div_rnd(p01 * a - p00 * b, 16, den, M_LIMIT);
        m2 = div_rnd(p10 * c - p11 * b, 16, den, M_LIMIT);
        m3 = div_rnd(p11 * a - p10 * b, 16, den, M_LIMIT);
        detm = m0 * m3 - m1 * m2;
        if (detm == 0) return res;
        adet = detm < 0 ? -detm : detm;
        pp00 = m0 * m0 + m1 * m1;
        pp01 = m0 * m2 + m1 * m3;
        pp11 = m2 * m2 + m3 * m3;
        qs = longint'(int_sqrt(64'(pp00) + 64'(pp11) + 2 * 64'(adet)));
        res.singular = 1'b0;
        res.s_xx = 32'(div_rnd(pp00 + adet, 0, qs, OUT_LIMIT));
        res.s_xy = 32'(div_rnd(pp01, 0, qs, OUT_LIMIT));
        res.s_yy = 32'(div_rnd(pp11 + adet, 0, qs, OUT_LIMIT));
        if (detm > 0) begin
            res.r_xx = 32'(div_rnd(m0 + m3, 16, qs, OUT_LIMIT));
            res.r_xy = 32'(div_rnd(m1 - m2, 16, qs, OUT_LIMIT));
            res.r_yx = 32'(div_rnd(m2 - m1, 16, qs, OUT_LIMIT));
            res.r_yy = res.r_xx;
        end else begin
            res.r_xx = 32'(div_rnd(m0 - m3, 16, qs, OUT_LIMIT));
            res.r_xy = 32'(div_rnd(m1 + m2, 16, qs, OUT_LIMIT));
            res.r_yx = res.r_xy;
            res.r_yy = 32'(div_rnd(m3 - m0, 16, qs, OUT_LIMIT));
        end
        return res;
    endfunction

    // fold one pair into the sums; on last, queue the expected shape
    function automatic void accumulate_pair(logic signed [CW-1:0] tx, ty, rx, ry, logic lst);
        cross_acc[0] += SUM_W'(longint'(tx) * longint'(rx));
        cross_acc[1] += SUM_W'(longint'(tx) * longint'(ry));
        cross_acc[2] += SUM_W'(longint'(ty) * longint'(rx));
        cross_acc[3] += SUM_W'(longint'(ty) * longint'(ry));
        ref_acc[0] += SUM_W'(longint'(rx) * longint'(rx));
        ref_acc[1] += SUM_W'(longint'(rx) * longint'(ry));
        ref_acc[2] += SUM_W'(longint'(ry) * longint'(ry));
        if (lst) begin
            expected_shapes.insert(expected_shapes.size(), solve_shape());
            for (int i = 0; i < 4; i++) cross_acc[i] = '0;
            for (int i = 0; i < 3; i++) ref_acc[i] = '0;
        end
    endfunction

    // send one pair beat, with optional idle cycles first
    task automatic send_pair(logic signed [CW-1:0] tx, ty, rx, ry, logic lst);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_trans_x <= tx; i_trans_y <= ty; i_ref_x <= rx; i_ref_y <= ry; i_last <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_pair(tx, ty, rx, ry, lst);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(int mode);
        unique case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(1024)) - 512);
            default: return CW'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // one random set of 2..8 pairs; t is roughly a linear map of r
    task automatic send_random_set();
        int n, mode, a00, a01, a10, a11;
        logic signed [CW-1:0] rx, ry;
        n = $urandom_range(8, 2);
        mode = $urandom_range(2);
        a00 = $signed($urandom_range(512)) - 256; a01 = $signed($urandom_range(512)) - 256;
        a10 = $signed($urandom_range(512)) - 256; a11 = $signed($urandom_range(512)) - 256;
        for (int i = 0; i < n; i++) begin
            rx = rnd_coord(mode);
            ry = rnd_coord(mode);
            if ($urandom_range(9) == 0)
                send_pair(rnd_coord(0), rnd_coord(0), rx, ry, i == n - 1);
            else
                send_pair(CW'((a00 * rx + a01 * ry) >>> 8), CW'((a10 * rx + a11 * ry) >>> 8),
                          rx, ry, i == n - 1);
        end
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        t_shape exp_s;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_shapes.size() == 0) begin
                $display("%t unexpected result beat", $time);
                errors++;
            end else begin
                exp_s = expected_shapes.pop_front();
                if ({o_s_xx, o_s_xy, o_s_yy, o_r_xx, o_r_xy, o_r_yx, o_r_yy, o_singular} !==
                    {exp_s.s_xx, exp_s.s_xy, exp_s.s_yy, exp_s.r_xx, exp_s.r_xy,
                     exp_s.r_yx, exp_s.r_yy, exp_s.singular}) begin
                    $display("%t mismatch exp S %0d %0d %0d R %0d %0d %0d %0d sing %0d",
                             $time, exp_s.s_xx, exp_s.s_xy, exp_s.s_yy, exp_s.r_xx,
                             exp_s.r_xy, exp_s.r_yx, exp_s.r_yy, exp_s.singular);
                    $display("%t   got S %0d %0d %0d R %0d %0d %0d %0d sing %0d",
                             $time, o_s_xx, o_s_xy, o_s_yy, o_r_xx, o_r_xy, o_r_yx,
                             o_r_yy, o_singular);
                    errors++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        localparam logic signed [CW-1:0] MX = 16'sh7FFF, MN = 16'sh8000;
        // identity map
        send_pair(16'sd256, 0, 16'sd256, 0, 0);
        send_pair(0, 16'sd256, 0, 16'sd256, 1);
        // reflection
        send_pair(-16'sd256, 0, 16'sd256, 0, 0);
        send_pair(0, 16'sd256, 0, 16'sd256, 1);
        // rotation by 90 degrees with scale
        send_pair(0, 16'sd512, 16'sd256, 0, 0);
        send_pair(-16'sd512, 0, 0, 16'sd256, 1);
        // singular reference: single point
        send_pair(16'sd100, 16'sd7, 16'sd300, -16'sd40, 1);
        // singular reference: all zero
        send_pair(0, 0, 0, 0, 1);
        // singular M: transformed points collinear
        send_pair(16'sd256, 16'sd256, 16'sd256, 0, 0);
        send_pair(16'sd512, 16'sd512, 0, 16'sd256, 1);
        // extremes, large sums and saturation
        send_pair(MX, MN, MX, MN, 0);
        send_pair(MN, MX, MN, MN, 0);
        send_pair(MX, MX, MX, MX, 0);
        send_pair(MN, MN, 16'sd1, MX, 1);
        send_pair(MX, MN, 16'sd1, 0, 0);
        send_pair(MN, MX, 0, 16'sd1, 1);
        send_pair(-16'sd1, 16'sd1, MN, 16'sd1, 0);
        send_pair(16'sd1, -16'sd1, -16'sd1, MN, 1);
    endtask

    // many full-range pairs in one set, deep block normalization
    task automatic test_long_set();
        for (int i = 0; i < 200; i++)
            send_pair(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom), i == 199);
    endtask

    task automatic test_random(int n_sets);
        for (int i = 0; i < n_sets; i++) send_random_set();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_shapes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 4; i++) cross_acc[i] = '0;
        for (int i = 0; i < 3; i++) ref_acc[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gap_pct = 7; recv_stall_pct = 47;
        test_directed();
        test_random(80);
        send_gap_pct = 47; recv_stall_pct = 7;
        test_random(80);
        test_long_set();
        send_gap_pct = 0; recv_stall_pct = 0;
        test_random(50);
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: files.f
src/psm_pkg.sv
src/psm_div.sv
src/psm_sqrt.sv
src/planar_shape_match_polar.sv
tb/tb_planar_shape_match_polar.sv
